// ===== design/swfr_pkg.sv =====
package swfr_pkg;

  // default number of stack entries
  localparam int unsigned DefStackDepth = 128;

  // word and field widths
  localparam int unsigned WordW  = 32;
  localparam int unsigned FuncW  = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned LevelW = 8;

  // cells examined per scan cycle during a find
  localparam int unsigned GroupW    = 8;
  localparam int unsigned GroupBitW = 3;

  // packed stream widths
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 48;

  // request codes
  typedef enum logic [FuncW-1:0] {
    OpPush = 2'd0,
    OpPop  = 2'd1,
    OpFind = 2'd2
  } swfr_op_e;

  // result codes
  typedef enum logic [StatW-1:0] {
    StOk       = 2'd0,
    StFull     = 2'd1,
    StEmpty    = 2'd2,
    StNotFound = 2'd3
  } swfr_status_e;

  // shift and compare control shared by all cells
  typedef struct packed {
    logic push;
    logic pop;
    logic cmp;
  } swfr_ctrl_t;

endpackage

// ===== design/swfr_cell.sv =====
module swfr_cell
  import swfr_pkg::*;
(
  input  logic             clk_i,
  input  swfr_ctrl_t       ctrl_i,
  input  logic             wr_i,
  input  logic [WordW-1:0] up_data_i,
  input  logic [WordW-1:0] dn_data_i,
  input  logic [WordW-1:0] wr_data_i,
  input  logic [WordW-1:0] tgt_i,
  output logic [WordW-1:0] data_o,
  output logic             match_o
);

  logic [WordW-1:0] data_q, data_d;
  logic             match_q;

  // push takes the word from above, pop the word from below, a write the replacement word
  always_comb begin
    data_d = data_q;
    if (ctrl_i.push) begin
      data_d = up_data_i;
    end else if (ctrl_i.pop) begin
      data_d = dn_data_i;
    end else if (wr_i) begin
      data_d = wr_data_i;
    end
  end

  // entry storage and local comparator
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    if (ctrl_i.cmp) begin
      match_q <= (data_q == tgt_i);
    end
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

// ===== design/stack_with_find_replace.sv =====
// channel  dir  tdata (low bit up)                          tuser
// s_axis   in   value[31:0] target[63:32]                   func[1:0]
// m_axis   out  read_word[31:0] status[33:32] level[41:34]  -
//
// push, pop and unused codes need no further state; the result lands in the output register
// find steps through the transfer, a compare in all cells, a scan over eight cells per cycle
// from the top down, and a final state that loads the result once the output register is free
// reset clears the fill count and the control registers, not the entries; entries need no clearing pass
// a new request is taken while a result waits only if that result leaves this cycle

module stack_with_find_replace
  import swfr_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DefStackDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // value[31:0], target[63:32]
  input  logic [FuncW-1:0]    s_axis_tuser,   // func[1:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // read_word, status, fill_level, zero pad
);

  localparam int unsigned CntW      = $clog2(STACK_DEPTH + 1);
  localparam int unsigned NumGroups = (STACK_DEPTH + GroupW - 1) / GroupW;
  localparam int unsigned GrpW      = (NumGroups > 1) ? $clog2(NumGroups) : 1;
  localparam int unsigned WrIdxW    = GrpW + GroupBitW;
  localparam int unsigned PadW      = NumGroups * GroupW;

  typedef enum logic [1:0] {
    SIdle,
    SCmp,
    SScan,
    SDone
  } state_e;

  state_e                 state_q;
  logic                   m_valid_q;
  logic [CntW-1:0]        cnt_q;
  logic [GrpW-1:0]        grp_q;
  swfr_status_e           st_q;
  logic [WordW-1:0]       rd_q;
  logic [LevelW-1:0]      lvl_q;
  logic [WordW-1:0]       tgt_q;
  logic [WordW-1:0]       val_q;

  logic [WordW-1:0]       in_value, in_target;
  logic                   out_free, acc, full, empty;
  swfr_ctrl_t             ctrl;
  logic [STACK_DEPTH-1:0] match, hit, wr;
  logic [PadW-1:0]        hit_pad;
  logic [GroupW-1:0]      grp_bits;
  logic [GroupBitW-1:0]   grp_k;
  logic                   grp_hit, wr_fire, last_grp;
  logic [WrIdxW-1:0]      wr_idx;
  logic [WordW-1:0]       cell_data [STACK_DEPTH];

  assign in_value  = s_axis_tdata[WordW-1:0];
  assign in_target = s_axis_tdata[2*WordW-1:WordW];

  // handshake and stack limits
  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == SIdle) && out_free;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign full          = (cnt_q == CntW'(STACK_DEPTH));
  assign empty         = (cnt_q == '0);

  // cell control
  assign ctrl.push = acc && (s_axis_tuser == OpPush) && !full;
  assign ctrl.pop  = acc && (s_axis_tuser == OpPop) && !empty;
  assign ctrl.cmp  = (state_q == SCmp);

  // row of cells, top of stack in cell zero
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [WordW-1:0] up_data, dn_data;
    if (i == 0) begin : g_top
      assign up_data = in_value;
    end else begin : g_mid
      assign up_data = cell_data[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign dn_data = cell_data[i];
    end else begin : g_up
      assign dn_data = cell_data[i+1];
    end
    assign hit[i] = match[i] && (CntW'(i) < cnt_q);
    assign wr[i]  = wr_fire && (wr_idx == WrIdxW'(i));

    swfr_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .wr_i      (wr[i]),
      .up_data_i (up_data),
      .dn_data_i (dn_data),
      .wr_data_i (val_q),
      .tgt_i     (tgt_q),
      .data_o    (cell_data[i]),
      .match_o   (match[i])
    );
  end

  // group scan: lowest hit in the current group of eight
  assign hit_pad  = PadW'(hit);
  assign grp_bits = hit_pad[grp_q*GroupW +: GroupW];
  assign grp_hit  = |grp_bits;
  assign last_grp = (grp_q == GrpW'(NumGroups - 1));
  assign wr_fire  = (state_q == SScan) && grp_hit;
  assign wr_idx   = {grp_q, grp_k};

  always_comb begin
    grp_k = '0;
    for (int k = GroupW - 1; k >= 0; k--) begin
      if (grp_bits[k]) begin
        grp_k = GroupBitW'(k);
      end
    end
  end

  // sequencer, count and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      m_valid_q <= 1'b0;
      cnt_q     <= '0;
      grp_q     <= '0;
      st_q      <= StOk;
      rd_q      <= '0;
      lvl_q     <= '0;
      tgt_q     <= '0;
      val_q     <= '0;
    end else begin
      if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (acc) begin
            rd_q <= '0;
            case (s_axis_tuser)
              OpPush: begin
                m_valid_q <= 1'b1;
                if (full) begin
                  st_q  <= StFull;
                  lvl_q <= LevelW'(cnt_q);
                end else begin
                  st_q  <= StOk;
                  cnt_q <= cnt_q + 1'b1;
                  lvl_q <= LevelW'(cnt_q + 1'b1);
                end
              end
              OpPop: begin
                m_valid_q <= 1'b1;
                if (empty) begin
                  st_q  <= StEmpty;
                  rd_q  <= '1;
                  lvl_q <= LevelW'(cnt_q);
                end else begin
                  st_q  <= StOk;
                  rd_q  <= cell_data[0];
                  cnt_q <= cnt_q - 1'b1;
                  lvl_q <= LevelW'(cnt_q - 1'b1);
                end
              end
              OpFind: begin
                tgt_q   <= in_target;
                val_q   <= in_value;
                grp_q   <= '0;
                state_q <= SCmp;
              end
              default: begin
                m_valid_q <= 1'b1;
                st_q      <= StOk;
                lvl_q     <= LevelW'(cnt_q);
              end
            endcase
          end
        end
        SCmp: begin
          state_q <= SScan;
        end
        SScan: begin
          if (grp_hit) begin
            st_q    <= StOk;
            state_q <= SDone;
          end else if (last_grp) begin
            st_q    <= StNotFound;
            state_q <= SDone;
          end else begin
            grp_q <= grp_q + 1'b1;
          end
        end
        SDone: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            rd_q      <= '0;
            lvl_q     <= LevelW'(cnt_q);
            state_q   <= SIdle;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OutDataW'({lvl_q, st_q, rd_q});

endmodule

// ===== dv/stack_with_find_replace_test.sv =====
`timescale 1ns / 1ps

module stack_with_find_replace_test;
  import swfr_pkg::*;

  localparam int unsigned Depth      = DefStackDepth;
  localparam int unsigned StallLimit = 2000;
  localparam logic [FuncW-1:0] OpUnused = 2'd3;

  // one expected result transfer
  typedef struct packed {
    logic [WordW-1:0]  read_word;
    swfr_status_e      status;
    logic [LevelW-1:0] fill_level;
  } stack_result_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // value[31:0], target[63:32]
  logic [FuncW-1:0]    s_axis_tuser = '0;   // func[1:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // read_word[31:0], status[33:32], fill_level[41:34]

  // predicted stack contents and the results still owed by the block
  logic [WordW-1:0] stack_mem [Depth];
  int unsigned      stack_count = 0;
  stack_result_t    pending_results [$];

  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_en = 1'b1;
  int unsigned stall_left = 0;

  stack_with_find_replace u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // apply one request to the predicted stack and return its result
  function automatic stack_result_t apply_request(logic [FuncW-1:0] func,
                                                  logic [WordW-1:0] val,
                                                  logic [WordW-1:0] tgt);
    stack_result_t res;
    int            idx;
    bit            hit;
    res.read_word = '0;
    res.status    = StOk;
    hit           = 1'b0;
    case (func)
      OpPush: begin
        if (stack_count >= Depth) begin
          res.status = StFull;
        end else begin
          stack_mem[stack_count] = val;
          stack_count++;
        end
      end
      OpPop: begin
        if (stack_count == 0) begin
          res.read_word = '1;
          res.status    = StEmpty;
        end else begin
          stack_count--;
          res.read_word = stack_mem[stack_count];
        end
      end
      OpFind: begin
        // topmost match wins
        for (idx = int'(stack_count) - 1; idx >= 0 && !hit; idx--) begin
          if (stack_mem[idx] == tgt) begin
            stack_mem[idx] = val;
            hit = 1'b1;
          end
        end
        if (!hit) res.status = StNotFound;
      end
      default: ;
    endcase
    res.fill_level = stack_count[LevelW-1:0];
    return res;
  endfunction

  // send one request transfer and record what it must produce
  task automatic send_request(input logic [FuncW-1:0] func, input logic [WordW-1:0] val,
                              input logic [WordW-1:0] tgt);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tgt, val};
    s_axis_tuser  <= func;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(apply_request(func, val, tgt));
  endtask

  // hold the sender until every owed result has come out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // compare one result transfer with the oldest prediction
  task automatic check_result(input logic [OutDataW-1:0] data);
    stack_result_t exp_res;
    logic [WordW-1:0]  got_word;
    logic [StatW-1:0]  got_status;
    logic [LevelW-1:0] got_level;
    got_word   = data[31:0];
    got_status = data[33:32];
    got_level  = data[41:34];
    if (pending_results.size() == 0) begin
      $error("unexpected result: read_word %0h status %0d fill_level %0d",
             got_word, got_status, got_level);
      error_count++;
    end else begin
      exp_res = pending_results.pop_front();
      if (got_word !== exp_res.read_word) begin
        $error("read_word: expected %0h, got %0h", exp_res.read_word, got_word);
        error_count++;
      end
      if (got_status !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, got_status);
        error_count++;
      end
      if (got_level !== exp_res.fill_level) begin
        $error("fill_level: expected %0d, got %0d", exp_res.fill_level, got_level);
        error_count++;
      end
    end
  endtask

  // result side: check transfers and stall in random bursts
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_en && rst_ni && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // pop, find and unused code on an empty stack
  task automatic test_empty_stack();
    send_request(OpPop, $urandom, $urandom);
    send_request(OpFind, $urandom, $urandom);
    send_request(OpUnused, $urandom, $urandom);
  endtask

  // extreme words come back in reverse order
  task automatic test_push_pop_extremes();
    send_request(OpPush, 32'h8000_0000, $urandom);
    send_request(OpPush, 32'h7fff_ffff, $urandom);
    send_request(OpPush, 32'hffff_ffff, $urandom);
    send_request(OpPush, 32'h0000_0000, $urandom);
    send_request(OpUnused, 32'hffff_ffff, 32'hffff_ffff);
    repeat (4) send_request(OpPop, $urandom, $urandom);
  endtask

  // topmost of duplicates is replaced, misses leave the stack alone
  task automatic test_find_replace();
    send_request(OpPush, 32'd5, $urandom);
    send_request(OpPush, 32'd7, $urandom);
    send_request(OpPush, 32'd5, $urandom);
    send_request(OpPush, 32'd9, $urandom);
    send_request(OpFind, 32'h1234_5678, 32'd5);
    send_request(OpFind, 32'h0bad_0bad, 32'h7fff_ffff);
    send_request(OpFind, 32'h8000_0000, 32'd9);
    send_request(OpFind, 32'hffff_ffff, 32'd5);
    repeat (4) send_request(OpPop, $urandom, $urandom);
  endtask

  // fill to the limit, refuse a push, search the bottom, drain past empty
  task automatic test_full_stack();
    logic [WordW-1:0] bottom;
    while (stack_count < Depth) send_request(OpPush, $urandom, $urandom);
    send_request(OpPush, $urandom, $urandom);
    bottom = stack_mem[0];
    send_request(OpFind, ~bottom, bottom);
    send_request(OpFind, $urandom, $urandom);
    send_request(OpUnused, $urandom, $urandom);
    while (stack_count > 0) send_request(OpPop, $urandom, $urandom);
    send_request(OpPop, $urandom, $urandom);
  endtask

  // mixed traffic with drifting push/pop balance, finds mostly aimed at held words
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned      k;
    int unsigned      roll;
    int unsigned      push_weight;
    logic [FuncW-1:0] func;
    logic [WordW-1:0] val;
    logic [WordW-1:0] tgt;
    push_weight = 50;
    for (k = 0; k < n_items; k++) begin
      if (k % 100 == 0) push_weight = $urandom_range(10, 90);
      if (k == n_items / 2) drain_results();
      if (k == n_items - n_items / 6) idle_en = 1'b0;
      val  = $urandom;
      tgt  = $urandom;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        func = OpUnused;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 30) func = OpFind;
        else if (roll < 30 + push_weight * 70 / 100) func = OpPush;
        else func = OpPop;
      end
      // reuse held words to build duplicates and hits
      if (stack_count > 0) begin
        if (func == OpPush && $urandom_range(0, 3) == 0)
          val = stack_mem[$urandom_range(0, stack_count - 1)];
        if (func == OpFind && $urandom_range(0, 9) < 7)
          tgt = stack_mem[$urandom_range(0, stack_count - 1)];
      end
      send_request(func, val, tgt);
    end
  endtask

  // test sequence
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_stack();
    test_push_pop_extremes();
    test_find_replace();
    test_full_stack();
    test_random_traffic(615);
    drain_results();
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/swfr_pkg.sv
design/swfr_cell.sv
design/stack_with_find_replace.sv
dv/stack_with_find_replace_test.sv
